[sv/s2ms_pkg.sv]
package s2ms_pkg;

  // Width of every matrix element and root element.
  localparam int DATA_W  = 32;
  // Width of the off-diagonal threshold register.
  localparam int THR_W   = 31;
  // Magnitude of a 32-bit signed value.
  localparam int MAG_W   = 32;
  // Exact discriminant (m11-m22)^2 + 4*m12^2 needs 65 bits and is held in 66.
  localparam int DISC_W  = 66;
  // Floor square root of the discriminant.
  localparam int DELTA_W = DISC_W / 2;
  // Signed width of the doubled eigenvalues and of the direction numerators.
  localparam int VAL_W   = 35;
  // Quotient bits kept by a divider; larger quotients only saturate.
  localparam int QUOT_W  = 33;
  // Divisor width: twice the discriminant root.
  localparam int DIV_W   = DELTA_W + 1;

endpackage

[sv/s2ms_sqrt_pipe.sv]
module s2ms_sqrt_pipe #(
  parameter int RadW = 66,
  parameter int SbW  = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [RadW-1:0]   rad_i,
  input  logic [SbW-1:0]    sb_i,
  output logic              valid_o,
  output logic [RadW/2-1:0] root_o,
  output logic [SbW-1:0]    sb_o
);

  // One result bit per stage, radicand consumed two bits at a time.
  localparam int K = RadW / 2;

  logic            vld_q  [K];
  logic [K+1:0]    rem_q  [K];
  logic [K-1:0]    root_q [K];
  logic [RadW-1:0] rad_q  [K];
  logic [SbW-1:0]  sb_q   [K];

  for (genvar j = 0; j < K; j++) begin : g_step
    logic            v_p;
    logic [K+1:0]    rem_p;
    logic [K-1:0]    root_p;
    logic [RadW-1:0] rad_p;
    logic [SbW-1:0]  sb_p;
    logic [K+3:0]    trial_v;
    logic [K+3:0]    test_v;
    logic            ge;

    if (j == 0) begin : g_first
      assign v_p    = valid_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad_i;
      assign sb_p   = sb_i;
    end else begin : g_next
      assign v_p    = vld_q[j-1];
      assign rem_p  = rem_q[j-1];
      assign root_p = root_q[j-1];
      assign rad_p  = rad_q[j-1];
      assign sb_p   = sb_q[j-1];
    end

    assign test_v  = {rem_p, rad_p[RadW-1 -: 2]};
    assign trial_v = (K+4)'({root_p, 2'b01});
    assign ge      = (test_v >= trial_v);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? (K+2)'(test_v - trial_v) : (K+2)'(test_v);
        root_q[j] <= {root_p[K-2:0], ge};
        rad_q[j]  <= rad_p << 2;
        sb_q[j]   <= sb_p;
      end
    end
  end

  assign valid_o = vld_q[K-1];
  assign root_o  = root_q[K-1];
  assign sb_o    = sb_q[K-1];

endmodule

[sv/s2ms_div_pipe.sv]
module s2ms_div_pipe #(
  parameter int NumW = 60,
  parameter int SbW  = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [NumW-1:0]             num_i,
  input  logic [s2ms_pkg::DIV_W-1:0]  den_i,
  input  logic [SbW-1:0]              sb_i,
  output logic                        valid_o,
  output logic [s2ms_pkg::QUOT_W-1:0] quot_o,
  output logic                        ovf_o,
  output logic [SbW-1:0]              sb_o
);

  import s2ms_pkg::*;

  // Stage 0 decides whether the quotient exceeds QUOT_W bits; the
  // following QUOT_W stages each produce one quotient bit.
  logic              vld_q  [QUOT_W+1];
  logic [DIV_W-1:0]  rem_q  [QUOT_W+1];
  logic [QUOT_W-1:0] low_q  [QUOT_W+1];
  logic [QUOT_W-1:0] quo_q  [QUOT_W+1];
  logic [DIV_W-1:0]  den_q  [QUOT_W+1];
  logic              ovf_q  [QUOT_W+1];
  logic [SbW-1:0]    sb_q   [QUOT_W+1];

  logic [NumW-1:0] num_hi;
  assign num_hi = num_i >> QUOT_W;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= DIV_W'(num_hi);
      low_q[0] <= num_i[QUOT_W-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      ovf_q[0] <= (num_hi >= NumW'(den_i));
      sb_q[0]  <= sb_i;
    end
  end

  for (genvar j = 1; j <= QUOT_W; j++) begin : g_step
    logic [DIV_W:0] test_v;
    logic           ge;

    assign test_v = {rem_q[j-1], low_q[j-1][QUOT_W-1]};
    assign ge     = (test_v >= {1'b0, den_q[j-1]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? DIV_W'(test_v - {1'b0, den_q[j-1]}) : DIV_W'(test_v);
        low_q[j] <= low_q[j-1] << 1;
        quo_q[j] <= {quo_q[j-1][QUOT_W-2:0], ge};
        den_q[j] <= den_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
        sb_q[j]  <= sb_q[j-1];
      end
    end
  end

  assign valid_o = vld_q[QUOT_W];
  assign quot_o  = quo_q[QUOT_W];
  assign ovf_o   = ovf_q[QUOT_W];
  assign sb_o    = sb_q[QUOT_W];

endmodule

[sv/symmetric_2x2_matrix_sqrt.sv]
// Throughput: one matrix per cycle; the whole pipeline advances together and halts
// only while a result beat waits at the output and is not taken.
// Reset: rst_ni is asynchronous, active low; it empties the pipeline and sets the
// off-diagonal threshold to 1. Data registers are not reset.
module symmetric_2x2_matrix_sqrt #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [30:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] m11_in_i,
  input  logic signed [31:0] m12_in_i,
  input  logic signed [31:0] m22_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] r11_out_o,
  output logic signed [31:0] r12_out_o,
  output logic signed [31:0] r22_out_o,
  output logic               negative_flag_o,
  output logic               overflow_flag_o
);

  import s2ms_pkg::*;

  // The eigenvalue roots use sqrt(2*lambda << (FRAC_BITS-1)); the radicand
  // is padded to an even width so the root pipeline takes two bits a stage.
  localparam int RAD_RAW = VAL_W - 1 + FRAC_BITS - 1;
  localparam int RAD_W   = RAD_RAW + (RAD_RAW % 2);
  localparam int ROOT_W  = RAD_W / 2;
  localparam int N11_W   = ROOT_W + VAL_W + 1;
  localparam int N12_W   = ROOT_W + MAG_W;

  // Operands after the input stage, carried alongside the discriminant root.
  typedef struct packed {
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] c;
    logic signed [DATA_W-1:0] b;
    logic [MAG_W-1:0]         bmag;
    logic                     diag_only;
  } op_t;

  // Terms carried alongside the eigenvalue roots.
  typedef struct packed {
    logic [VAL_W-1:0]         p;
    logic [VAL_W-1:0]         q;
    logic [MAG_W-1:0]         bmag;
    logic signed [DATA_W-1:0] b;
    logic [DELTA_W-1:0]       delta;
    logic                     diag_only;
    logic                     negx;
  } dir_t;

  // Terms carried through the main divider.
  typedef struct packed {
    logic [ROOT_W-1:0] sx;
    logic [ROOT_W-1:0] sy;
    logic              negf;
    logic              diag_only;
  } fin_t;

  // The whole pipeline moves whenever the output register can take a beat.
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  logic [THR_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_W'(1);
    end else if (cfg_we_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------------
  // Stage A: absolute difference of the diagonal, |m12|, threshold test.
  // ---------------------------------------------------------------------
  logic signed [DATA_W:0] dsub;
  logic [DATA_W:0]        diff_a;
  logic [MAG_W-1:0]       bmag_a;

  assign dsub   = (DATA_W+1)'(m11_in_i) - (DATA_W+1)'(m22_in_i);
  assign diff_a = dsub[DATA_W] ? (DATA_W+1)'(-dsub) : (DATA_W+1)'(dsub);
  assign bmag_a = m12_in_i[DATA_W-1] ? MAG_W'(-m12_in_i) : MAG_W'(m12_in_i);

  logic            va_q;
  op_t             opa_q;
  logic [DATA_W:0] diff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      opa_q.a         <= m11_in_i;
      opa_q.c         <= m22_in_i;
      opa_q.b         <= m12_in_i;
      opa_q.bmag      <= bmag_a;
      opa_q.diag_only <= (bmag_a < MAG_W'(thr_q));
      diff_q          <= diff_a;
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: the two squares of the discriminant.
  // Stage C: their sum, 4*m12^2 being a shift of m12^2.
  // ---------------------------------------------------------------------
  logic              vb_q, vc_q;
  op_t               opb_q, opc_q;
  logic [DISC_W-1:0] sqd_q;
  logic [DISC_W-1:0] sqb_q;
  logic [DISC_W-1:0] disc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en) begin
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqd_q  <= DISC_W'(diff_q) * DISC_W'(diff_q);
      sqb_q  <= DISC_W'(opa_q.bmag) * DISC_W'(opa_q.bmag);
      opb_q  <= opa_q;
      disc_q <= sqd_q + (sqb_q << 2);
      opc_q  <= opb_q;
    end
  end

  // ---------------------------------------------------------------------
  // Discriminant root D, one bit per stage.
  // ---------------------------------------------------------------------
  logic               vdl;
  logic [DELTA_W-1:0] delta;
  logic [$bits(op_t)-1:0] opdl_v;
  op_t                opdl;

  s2ms_sqrt_pipe #(
    .RadW (DISC_W),
    .SbW  ($bits(op_t))
  ) u_disc_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vc_q),
    .rad_i   (disc_q),
    .sb_i    (opc_q),
    .valid_o (vdl),
    .root_o  (delta),
    .sb_o    (opdl_v)
  );

  assign opdl = op_t'(opdl_v);

  // ---------------------------------------------------------------------
  // Stage D: doubled eigenvalues and direction numerators. On the small
  // off-diagonal path the root inputs become 2*m11 and 2*m22, which after
  // the common shift by FRAC_BITS-1 give sqrt(m << FRAC_BITS).
  // ---------------------------------------------------------------------
  logic signed [VAL_W-1:0] sum_ac, dl, twice_lx, twice_ly, p_s, q_s;
  logic                    diag_only_d;

  assign sum_ac   = VAL_W'(opdl.a) + VAL_W'(opdl.c);
  assign dl       = signed'(VAL_W'(delta));
  assign twice_lx = sum_ac + dl;
  assign twice_ly = sum_ac - dl;
  assign p_s      = VAL_W'(opdl.a) - VAL_W'(opdl.c) + dl;
  assign q_s      = VAL_W'(opdl.c) - VAL_W'(opdl.a) + dl;
  // A zero discriminant only occurs for a diagonal matrix, so it joins the
  // small off-diagonal path.
  assign diag_only_d = opdl.diag_only || (delta == '0);

  logic                    vd_q;
  logic signed [VAL_W-1:0] vx_q, vy_q;
  dir_t                    dird_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (en) begin
      vd_q <= vdl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vx_q             <= diag_only_d ? VAL_W'(opdl.a) + VAL_W'(opdl.a) : twice_lx;
      vy_q             <= diag_only_d ? VAL_W'(opdl.c) + VAL_W'(opdl.c) : twice_ly;
      dird_q.p         <= p_s;
      dird_q.q         <= q_s;
      dird_q.bmag      <= opdl.bmag;
      dird_q.b         <= opdl.b;
      dird_q.delta     <= delta;
      dird_q.diag_only <= diag_only_d;
      dird_q.negx      <= 1'b0;
    end
  end

  // Negative radicands are clamped to zero and flagged.
  logic             negx, negy;
  logic [RAD_W-1:0] radx, rady;
  dir_t             dirx_in;

  assign negx = vx_q[VAL_W-1];
  assign negy = vy_q[VAL_W-1];
  assign radx = negx ? '0 : (RAD_W'(vx_q[VAL_W-2:0]) << (FRAC_BITS - 1));
  assign rady = negy ? '0 : (RAD_W'(vy_q[VAL_W-2:0]) << (FRAC_BITS - 1));

  always_comb begin
    dirx_in      = dird_q;
    dirx_in.negx = negx;
  end

  // ---------------------------------------------------------------------
  // Eigenvalue roots sx and sy, side by side.
  // ---------------------------------------------------------------------
  logic                    vxr, vyr_unused_free;
  logic [ROOT_W-1:0]       sx, sy;
  logic [$bits(dir_t)-1:0] dirx_v;
  dir_t                    dirx;
  logic                    negy_r;

  s2ms_sqrt_pipe #(
    .RadW (RAD_W),
    .SbW  ($bits(dir_t))
  ) u_x_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vd_q),
    .rad_i   (radx),
    .sb_i    (dirx_in),
    .valid_o (vxr),
    .root_o  (sx),
    .sb_o    (dirx_v)
  );

  s2ms_sqrt_pipe #(
    .RadW (RAD_W),
    .SbW  (1)
  ) u_y_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vd_q),
    .rad_i   (rady),
    .sb_i    (negy),
    .valid_o (vyr_unused_free),
    .root_o  (sy),
    .sb_o    (negy_r)
  );

  assign dirx = dir_t'(dirx_v);

  // ---------------------------------------------------------------------
  // Stage E: products of the roots with the direction numerators.
  // Stage F: numerator sums; the divisors 2*D and D are formed here.
  // ---------------------------------------------------------------------
  logic [ROOT_W-1:0] sdiff;
  assign sdiff = (sx >= sy) ? (sx - sy) : '0;

  logic                     ve_q, vf_q;
  logic [N11_W-1:0]         pxp_q, pyq_q, pxq_q, pyp_q;
  logic [N12_W-1:0]         p12_q;
  fin_t                     fine_q, finf_q;
  logic signed [DATA_W-1:0] be_q, bf_q;
  logic [DELTA_W-1:0]       de_q, df_q;
  logic [N11_W-1:0]         n11_q, n22_q;
  logic [N12_W-1:0]         n12_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
      vf_q <= 1'b0;
    end else if (en) begin
      ve_q <= vxr;
      vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pxp_q            <= N11_W'(sx) * N11_W'(dirx.p);
      pyq_q            <= N11_W'(sy) * N11_W'(dirx.q);
      pxq_q            <= N11_W'(sx) * N11_W'(dirx.q);
      pyp_q            <= N11_W'(sy) * N11_W'(dirx.p);
      p12_q            <= N12_W'(sdiff) * N12_W'(dirx.bmag);
      fine_q.sx        <= sx;
      fine_q.sy        <= sy;
      fine_q.negf      <= dirx.negx || negy_r;
      fine_q.diag_only <= dirx.diag_only;
      be_q             <= dirx.b;
      de_q             <= dirx.delta;

      n11_q            <= pxp_q + pyq_q;
      n22_q            <= pxq_q + pyp_q;
      n12_q            <= p12_q;
      finf_q           <= fine_q;
      bf_q             <= be_q;
      df_q             <= de_q;
    end
  end

  // ---------------------------------------------------------------------
  // Three dividers: r11 and r22 over 2*D, |r12| over D.
  // ---------------------------------------------------------------------
  logic                     v11, v12_free, v22_free;
  logic [QUOT_W-1:0]        q11, q12, q22;
  logic                     o11, o12, o22;
  logic [$bits(fin_t)-1:0]  fin_v;
  fin_t                     fin;
  logic [DATA_W-1:0]        b_r;
  logic                     negf_r;

  s2ms_div_pipe #(
    .NumW (N11_W),
    .SbW  ($bits(fin_t))
  ) u_div11 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vf_q),
    .num_i   (n11_q),
    .den_i   ({df_q, 1'b0}),
    .sb_i    (finf_q),
    .valid_o (v11),
    .quot_o  (q11),
    .ovf_o   (o11),
    .sb_o    (fin_v)
  );

  s2ms_div_pipe #(
    .NumW (N12_W),
    .SbW  (DATA_W)
  ) u_div12 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vf_q),
    .num_i   (n12_q),
    .den_i   ({1'b0, df_q}),
    .sb_i    (bf_q),
    .valid_o (v12_free),
    .quot_o  (q12),
    .ovf_o   (o12),
    .sb_o    (b_r)
  );

  s2ms_div_pipe #(
    .NumW (N11_W),
    .SbW  (1)
  ) u_div22 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vf_q),
    .num_i   (n22_q),
    .den_i   ({df_q, 1'b0}),
    .sb_i    (finf_q.negf),
    .valid_o (v22_free),
    .quot_o  (q22),
    .ovf_o   (o22),
    .sb_o    (negf_r)
  );

  assign fin = fin_t'(fin_v);

  // ---------------------------------------------------------------------
  // Output stage: saturation and selection of the small off-diagonal path.
  // ---------------------------------------------------------------------
  localparam logic [QUOT_W-1:0] POS_LIM = QUOT_W'(32'h7FFF_FFFF);
  localparam logic [QUOT_W-1:0] NEG_LIM = QUOT_W'(32'h8000_0000);

  logic              s11, s22, sdx, sdy, s12;
  logic [QUOT_W-1:0] m12_lim, m12_mag, m12_neg;
  logic [QUOT_W-1:0] sx_w, sy_w;
  logic              bneg;

  assign sx_w    = QUOT_W'(fin.sx);
  assign sy_w    = QUOT_W'(fin.sy);
  assign s11     = o11 || (q11 > POS_LIM);
  assign s22     = o22 || (q22 > POS_LIM);
  assign sdx     = (sx_w > POS_LIM);
  assign sdy     = (sy_w > POS_LIM);
  assign bneg    = b_r[DATA_W-1];
  assign m12_lim = bneg ? NEG_LIM : POS_LIM;
  assign s12     = o12 || (q12 > m12_lim);
  assign m12_mag = s12 ? m12_lim : q12;
  assign m12_neg = QUOT_W'(0) - m12_mag;

  logic                     vo_q;
  logic signed [DATA_W-1:0] r11_q, r12_q, r22_q;
  logic                     negf_q, ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en) begin
      vo_q <= v11;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      negf_q <= negf_r;
      if (fin.diag_only) begin
        r11_q <= sdx ? DATA_W'(POS_LIM) : DATA_W'(sx_w);
        r12_q <= b_r;
        r22_q <= sdy ? DATA_W'(POS_LIM) : DATA_W'(sy_w);
        ovf_q <= sdx || sdy;
      end else begin
        r11_q <= s11 ? DATA_W'(POS_LIM) : DATA_W'(q11);
        r12_q <= bneg ? DATA_W'(m12_neg) : DATA_W'(m12_mag);
        r22_q <= s22 ? DATA_W'(POS_LIM) : DATA_W'(q22);
        ovf_q <= s11 || s12 || s22;
      end
    end
  end

  assign out_valid_o     = vo_q;
  assign r11_out_o       = r11_q;
  assign r12_out_o       = r12_q;
  assign r22_out_o       = r22_q;
  assign negative_flag_o = negf_q;
  assign overflow_flag_o = ovf_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------

  // The diagonal of the root is never negative unless saturation hit it.
  a_diag_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !overflow_flag_o |-> !r11_out_o[31] && !r22_out_o[31])
    else $error("root diagonal negative without overflow");

  // An overflow flag means some element sits at a saturation bound.
  a_ovf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_flag_o |->
      r11_out_o == 32'sh7FFF_FFFF || r22_out_o == 32'sh7FFF_FFFF ||
      r12_out_o == 32'sh7FFF_FFFF || r12_out_o == -32'sh8000_0000)
    else $error("overflow flag without a saturated element");

  // A waiting result beat halts intake, so nothing in flight is overwritten.
  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while the pipeline is stalled");

endmodule
